[rtl/cthm_pkg.sv]
// ----------------------------------------------------------------------------
// Channel time histogram package
// Shared widths, operation and status codes, and beat structures.
// ----------------------------------------------------------------------------
package cthm_pkg;

	localparam int CHANNELS_DEF   = 256;
	localparam int BINS_DEF       = 512;
	localparam int HALF_RANGE_DEF = 256;

	localparam int CNT_W   = 24;
	localparam int CH_IN_W = 8;
	localparam int TIME_W  = 13;
	localparam int OFF_W   = 12;
	localparam int MEAN_W  = 16;
	localparam int POS_W   = 15;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic signed [MEAN_W-1:0] MEAN_MAX = 16'sh7fff;
	localparam logic signed [MEAN_W-1:0] MEAN_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_FILL  = 2'd1,
		OP_QUERY = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUMMY = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	localparam logic CFG_MIN_ENTRIES = 1'b0;
	localparam logic CFG_INVALID_TIME = 1'b1;

	typedef struct packed {
		op_t                       op;
		logic [CH_IN_W-1:0]        channel;
		logic signed [TIME_W-1:0]  hit_time;
		logic signed [OFF_W-1:0]   offset_value;
	} item_t;

	typedef struct packed {
		status_t                   status;
		logic signed [MEAN_W-1:0]  mean_time;
		logic [CNT_W-1:0]          channel_entries;
		logic                      enough_entries;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

endpackage

[rtl/cthm_div.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cthm_div import cthm_pkg::*; #(
	parameter int N = 50
) (
	input  logic          clk,
	input  logic          arst_n,
	input  div_req_t      req,
	input  logic [N-1:0]  dividend,
	output logic          done,
	output logic [N-1:0]  quot
);

	localparam int CW = $clog2(N + 1);

	logic [N-1:0]     q_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] d_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             fit;

	assign trial = {rem_q, q_q[N-1]};
	assign diff  = trial - {1'b0, d_q};
	assign fit   = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			q_q    <= '0;
			rem_q  <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				q_q   <= dividend;
				rem_q <= '0;
				d_q   <= req.divisor;
			end else if (run_q) begin
				q_q   <= {q_q[N-2:0], fit};
				rem_q <= fit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(N - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

[rtl/cthm_seq.sv]
// ----------------------------------------------------------------------------
// Histogram sequencer
// Holds the bin, hit count and offset memories and steps each operation.
// ----------------------------------------------------------------------------
module cthm_seq import cthm_pkg::*; #(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int BINS       = BINS_DEF,
	parameter int HALF_RANGE = HALF_RANGE_DEF,
	parameter int SUM_W      = 50
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  item_t                     in_item,
	input  logic [CNT_W-1:0]          min_entries,
	input  logic signed [TIME_W-1:0]  invalid_time_code,
	output logic                      res_valid,
	input  logic                      res_ready,
	output result_t                   res,
	output div_req_t                  div_req,
	output logic [SUM_W-1:0]          div_dividend,
	input  logic                      div_done,
	input  logic [SUM_W-1:0]          div_quot
);

	localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int BIN_W   = $clog2(BINS);
	localparam int DEPTH   = CHANNELS * BINS;
	localparam int BADDR_W = $clog2(DEPTH);
	localparam int WK_W    = BADDR_W + 1;
	localparam int MAG_W   = $clog2(((BINS > HALF_RANGE) ? BINS : HALF_RANGE) + 1);
	localparam int DIFF_W  = MAG_W + 1;
	localparam int PROD_W  = CNT_W + DIFF_W;

	typedef enum logic [7:0] {
		S_CLR  = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_EXEC = 8'b0000_0100,
		S_BWR  = 8'b0000_1000,
		S_ENQ  = 8'b0001_0000,
		S_SUM  = 8'b0010_0000,
		S_DIV  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]        bin_mem [DEPTH];
	logic [CNT_W-1:0]        hit_mem [CHANNELS];
	logic signed [OFF_W-1:0] off_mem [CHANNELS];

	logic [CNT_W-1:0]        bin_rd_q;
	logic [CNT_W-1:0]        hit_rd_q;
	logic signed [OFF_W-1:0] off_rd_q;

	item_t                   item_q;
	logic                    dummy_q;
	logic                    wipe_off_q;
	logic [WK_W-1:0]         wk_q;
	logic                    v_s1;
	logic [BIN_W-1:0]        bidx_s1;
	logic                    v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0] acc_q;
	logic                    enough_q;
	logic [CNT_W-1:0]        entries_q;
	logic [BADDR_W-1:0]      base_q;
	logic [BADDR_W-1:0]      bwaddr_q;
	logic                    neg_q;
	logic [SUM_W-1:0]        mag_q;
	logic                    div_start_q;
	result_t                 res_q;

	logic [CH_W-1:0]         ch_idx;
	logic [BADDR_W-1:0]      ch_base;
	logic signed [POS_W-1:0] pos;
	logic                    in_range;
	logic [BADDR_W-1:0]      fill_addr;
	logic [CNT_W-1:0]        hit_inc;
	logic                    fill_bad;
	logic signed [DIFF_W-1:0] diff;
	logic signed [MEAN_W-1:0] sat_mean;

	logic [CH_W-1:0]         hit_raddr;
	logic                    hit_we;
	logic [CH_W-1:0]         hit_waddr;
	logic [CNT_W-1:0]        hit_wdata;
	logic                    off_we;
	logic [CH_W-1:0]         off_waddr;
	logic signed [OFF_W-1:0] off_wdata;
	logic [BADDR_W-1:0]      bin_raddr;
	logic                    bin_we;
	logic [BADDR_W-1:0]      bin_waddr;
	logic [CNT_W-1:0]        bin_wdata;

	assign ch_idx    = item_q.channel[CH_W-1:0];
	assign ch_base   = BADDR_W'(ch_idx) * BADDR_W'(BINS);
	assign pos       = POS_W'(item_q.hit_time) + POS_W'(off_rd_q) + POS_W'(HALF_RANGE);
	assign in_range  = (pos >= 0) && (pos < $signed(POS_W'(BINS)));
	assign fill_addr = ch_base + BADDR_W'($unsigned(pos));
	assign hit_inc   = sat_inc(hit_rd_q);
	assign fill_bad  = dummy_q || (item_q.hit_time == invalid_time_code);
	assign diff      = $signed(DIFF_W'(bidx_s1)) - $signed(DIFF_W'(HALF_RANGE));

	always_comb begin
		if (!neg_q) begin
			sat_mean = (div_quot > SUM_W'(32767)) ? MEAN_MAX : div_quot[MEAN_W-1:0];
		end else begin
			sat_mean = (div_quot > SUM_W'(32768)) ? MEAN_MIN : MEAN_W'(-div_quot);
		end
	end

	always_comb begin
		hit_raddr = (state_q == S_ENQ) ? wk_q[CH_W-1:0] : in_item.channel[CH_W-1:0];
		bin_raddr = (state_q == S_SUM) ? base_q + BADDR_W'(wk_q[BIN_W-1:0]) : fill_addr;
		hit_we    = 1'b0;
		hit_waddr = ch_idx;
		hit_wdata = hit_inc;
		off_we    = 1'b0;
		off_waddr = ch_idx;
		off_wdata = item_q.offset_value;
		bin_we    = 1'b0;
		bin_waddr = bwaddr_q;
		bin_wdata = sat_inc(bin_rd_q);
		case (state_q)
			S_CLR: begin
				bin_we    = 1'b1;
				bin_waddr = wk_q[BADDR_W-1:0];
				bin_wdata = '0;
				hit_we    = wk_q < WK_W'(CHANNELS);
				hit_waddr = wk_q[CH_W-1:0];
				hit_wdata = '0;
				off_we    = wipe_off_q && (wk_q < WK_W'(CHANNELS));
				off_waddr = wk_q[CH_W-1:0];
				off_wdata = '0;
			end
			S_EXEC: begin
				hit_we = (item_q.op == OP_FILL) && !fill_bad;
				off_we = (item_q.op == OP_LOAD) && !dummy_q;
			end
			S_BWR: begin
				bin_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (bin_we) begin
			bin_mem[bin_waddr] <= bin_wdata;
		end
		bin_rd_q <= bin_mem[bin_raddr];
	end

	always_ff @(posedge clk) begin
		if (hit_we) begin
			hit_mem[hit_waddr] <= hit_wdata;
		end
		hit_rd_q <= hit_mem[hit_raddr];
	end

	always_ff @(posedge clk) begin
		if (off_we) begin
			off_mem[off_waddr] <= off_wdata;
		end
		off_rd_q <= off_mem[in_item.channel[CH_W-1:0]];
	end

	always_ff @(posedge clk) begin
		bidx_s1 <= wk_q[BIN_W-1:0];
		prod_s2 <= PROD_W'($signed({1'b0, bin_rd_q})) * PROD_W'(diff);
		if (v_s2) begin
			acc_q <= acc_q + SUM_W'(prod_s2);
		end else if (state_q == S_ENQ) begin
			acc_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			wk_q        <= '0;
			wipe_off_q  <= 1'b1;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= (state_q == S_SUM) && v_s1;
			case (state_q)
				S_CLR: begin
					wk_q <= wk_q + 1'b1;
					if (wk_q == WK_W'(DEPTH - 1)) begin
						wk_q <= '0;
						if (wipe_off_q) begin
							wipe_off_q <= 1'b0;
							state_q    <= S_IDLE;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_item;
						dummy_q <= {1'b0, in_item.channel} >= (CH_IN_W + 1)'(CHANNELS);
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_q <= '{status: ST_OK, mean_time: '0, channel_entries: '0,
						enough_entries: 1'b0};
					state_q <= S_OUT;
					case (item_q.op)
						OP_LOAD: begin
							if (dummy_q) begin
								res_q.status <= ST_DUMMY;
							end else begin
								res_q.channel_entries <= hit_rd_q;
							end
						end
						OP_FILL: begin
							if (dummy_q) begin
								res_q.status <= ST_DUMMY;
							end else if (fill_bad) begin
								res_q.status          <= ST_DUMMY;
								res_q.channel_entries <= hit_rd_q;
							end else begin
								res_q.channel_entries <= hit_inc;
								if (in_range) begin
									bwaddr_q <= fill_addr;
									state_q  <= S_BWR;
								end
							end
						end
						OP_QUERY: begin
							wk_q      <= '0;
							enough_q  <= 1'b1;
							entries_q <= hit_rd_q;
							base_q    <= ch_base;
							state_q   <= S_ENQ;
						end
						OP_CLEAR: begin
							wk_q    <= '0;
							state_q <= S_CLR;
						end
						default: begin
						end
					endcase
				end
				S_BWR: begin
					state_q <= S_OUT;
				end
				S_ENQ: begin
					if (wk_q != WK_W'(CHANNELS)) begin
						wk_q <= wk_q + 1'b1;
						v_s1 <= 1'b1;
					end
					if (v_s1 && (hit_rd_q <= min_entries)) begin
						enough_q <= 1'b0;
					end
					if ((wk_q == WK_W'(CHANNELS)) && !v_s1) begin
						res_q.enough_entries <= enough_q;
						wk_q <= '0;
						if (dummy_q) begin
							res_q.status <= ST_DUMMY;
							state_q      <= S_OUT;
						end else if (entries_q == '0) begin
							res_q.status <= ST_EMPTY;
							state_q      <= S_OUT;
						end else begin
							res_q.channel_entries <= entries_q;
							state_q <= S_SUM;
						end
					end
				end
				S_SUM: begin
					if (wk_q != WK_W'(BINS)) begin
						wk_q <= wk_q + 1'b1;
						v_s1 <= 1'b1;
					end
					if ((wk_q == WK_W'(BINS)) && !v_s1 && !v_s2) begin
						neg_q       <= acc_q[SUM_W-1];
						mag_q       <= acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						res_q.mean_time <= sat_mean;
						state_q         <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready        = (state_q == S_IDLE);
	assign res_valid       = (state_q == S_OUT);
	assign res             = res_q;
	assign div_req.start   = div_start_q;
	assign div_req.divisor = entries_q;
	assign div_dividend    = mag_q;

endmodule

[rtl/channel_time_histogram_mean.sv]
// ----------------------------------------------------------------------------
// Channel time histogram with mean query
// Per-channel hit time histograms, hit counts and offsets behind a stream port.
// ----------------------------------------------------------------------------
// Input beats carry one operation each (load offset, fill, query, clear) with
// the operation code in s_tuser. Every beat produces exactly one result beat.
// The block takes one beat at a time: s_tready is high only while it waits.
// For a load or an out-of-range or dropped fill, the sequencer steps from S_EXEC
// to S_OUT and the result then passes into the output register behind m_tvalid;
// an in-range fill adds the state S_BWR (read-modify-write of the bin memory).
// A query walks all CHANNELS hit counts, then all BINS bins of the channel
// through one multiply-accumulate, then the serial divider. Clear sweeps the
// bin memory and the hit counts. After reset the same sweep, also wiping the
// offsets, runs before the first beat is taken; configuration writes are taken
// throughout.
// The result waits in an output register; a stalled receiver holds it there
// and the block can accept the next beat meanwhile.
// ----------------------------------------------------------------------------
module channel_time_histogram_mean import cthm_pkg::*; #(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int BINS       = BINS_DEF,
	parameter int HALF_RANGE = HALF_RANGE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // channel, hit_time, offset_value
	input  logic [1:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // mean_time, channel_entries, enough_entries
	output logic [1:0]  m_tuser,   // status
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int MAG_W  = $clog2(((BINS > HALF_RANGE) ? BINS : HALF_RANGE) + 1);
	localparam int DIFF_W = MAG_W + 1;
	localparam int SUM_W  = CNT_W + DIFF_W + $clog2(BINS);

	logic [CNT_W-1:0]         min_entries_q;
	logic signed [TIME_W-1:0] invalid_time_q;
	logic                     out_valid_q;
	result_t                  out_q;
	item_t                    in_item;
	result_t                  res;
	logic                     res_valid;
	logic                     res_ready;
	div_req_t                 div_req;
	logic [SUM_W-1:0]         div_dividend;
	logic                     div_done;
	logic [SUM_W-1:0]         div_quot;

	assign in_item.op           = op_t'(s_tuser);
	assign in_item.channel      = s_tdata[7:0];
	assign in_item.hit_time     = s_tdata[20:8];
	assign in_item.offset_value = s_tdata[32:21];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_entries_q  <= '0;
			invalid_time_q <= 13'sh1000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_ENTRIES: min_entries_q <= cfg_data;
				CFG_INVALID_TIME: invalid_time_q <= cfg_data[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	cthm_seq #(
		.CHANNELS   (CHANNELS),
		.BINS       (BINS),
		.HALF_RANGE (HALF_RANGE),
		.SUM_W      (SUM_W)
	) u_seq (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (s_tvalid),
		.in_ready          (s_tready),
		.in_item           (in_item),
		.min_entries       (min_entries_q),
		.invalid_time_code (invalid_time_q),
		.res_valid         (res_valid),
		.res_ready         (res_ready),
		.res               (res),
		.div_req           (div_req),
		.div_dividend      (div_dividend),
		.div_done          (div_done),
		.div_quot          (div_quot)
	);

	cthm_div #(
		.N (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_q.enough_entries, out_q.channel_entries, out_q.mean_time};
	assign m_tuser  = out_q.status;

endmodule

[rtl/cthm_chk.sv]
// ----------------------------------------------------------------------------
// Channel time histogram checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module cthm_chk import cthm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [39:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        cfg_we,
	input logic        cfg_index,
	input logic [23:0] cfg_data
);

	// The block works on one beat at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a beat is in progress");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result beat changed");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_DUMMY) || (m_tuser == ST_EMPTY))
		else $error("undefined status code");

	a_dummy_mean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_DUMMY) |-> m_tdata[15:0] == 16'd0)
		else $error("dropped beat carries a mean");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[15:0] == 16'd0) && (m_tdata[39:16] == 24'd0))
		else $error("empty channel result carries data");

endmodule

bind channel_time_histogram_mean cthm_chk u_cthm_chk (.*);
